FILE: src/coverage_end_trim_segmenter_defines.svh
// ----------------------------------------------------------------------------
// coverage_end_trim_segmenter_defines
// assertion macros used by cets_emit, empty when SYNTH is set
// ----------------------------------------------------------------------------
`ifndef COVERAGE_END_TRIM_SEGMENTER_DEFINES_SVH
`define COVERAGE_END_TRIM_SEGMENTER_DEFINES_SVH

`ifndef SYNTH
// property that holds on every clock edge outside reset
`define CETS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// consequence that holds in the cycle after the antecedent
`define CETS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define CETS_ASSERT(lbl, prop, msg)
`define CETS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: src/cets_pkg.sv
// ----------------------------------------------------------------------------
// cets_pkg
// widths, defaults and types of the coverage end trim segmenter
// ----------------------------------------------------------------------------
package cets_pkg;

  localparam int unsigned POS_BITS_DEF = 32;
  localparam int unsigned IN_POS_W     = 32;
  localparam int unsigned OUT_POS_W    = 32;
  localparam int unsigned COV_W        = 24;
  localparam int unsigned COV_FRAC     = 8;
  localparam int unsigned THR_W        = 16;
  localparam int unsigned NSEG         = 3;
  localparam int unsigned SEG_CNT_W    = 2;
  localparam int unsigned S_TDATA_W    = 3 * IN_POS_W + COV_W;
  localparam int unsigned M_TDATA_W    = 2 * OUT_POS_W;

  typedef enum logic [1:0] {
    CASE_BOTH,
    CASE_LEFT,
    CASE_RIGHT,
    CASE_WHOLE
  } trim_case_t;

endpackage

FILE: src/cets_track.sv
// ----------------------------------------------------------------------------
// cets_track
// threshold register, leading and trailing low-run tracking, job register
// ----------------------------------------------------------------------------
module cets_track #(
  parameter int unsigned POS_BITS = cets_pkg::POS_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  input  logic [cets_pkg::THR_W-1:0]    cfg_data,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [cets_pkg::S_TDATA_W-1:0] s_axis_tdata,
  input  logic                          s_axis_tlast,
  output logic                          job_valid,
  input  logic                          job_take,
  output logic [POS_BITS-1:0]           job_l,
  output logic [POS_BITS-1:0]           job_r,
  output logic [POS_BITS-1:0]           job_s
);
  import cets_pkg::*;

  logic [THR_W-1:0]    min_coverage;
  logic                in_prefix;
  logic [POS_BITS-1:0] prefix_end;
  logic                suffix_active;
  logic [POS_BITS-1:0] suffix_start;

  logic                          accept;
  logic [POS_BITS+IN_POS_W-1:0]  ws_wide, we_wide, sz_wide;
  logic [POS_BITS-1:0]           ws, we, sz;
  logic [COV_W-1:0]              cov;
  logic                          low;
  logic                          in_prefix_next;
  logic [POS_BITS-1:0]           prefix_end_next;
  logic [POS_BITS-1:0]           suffix_start_next;

  assign accept  = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = !job_valid || job_take;

  assign ws_wide = {{POS_BITS{1'b0}}, s_axis_tdata[IN_POS_W-1:0]};
  assign we_wide = {{POS_BITS{1'b0}}, s_axis_tdata[2*IN_POS_W-1:IN_POS_W]};
  assign sz_wide = {{POS_BITS{1'b0}}, s_axis_tdata[S_TDATA_W-1:2*IN_POS_W+COV_W]};
  assign ws  = ws_wide[POS_BITS-1:0];
  assign we  = we_wide[POS_BITS-1:0];
  assign sz  = sz_wide[POS_BITS-1:0];
  assign cov = s_axis_tdata[2*IN_POS_W+COV_W-1:2*IN_POS_W];

  // whole-number part below threshold
  assign low = cov[COV_W-1:COV_FRAC] < min_coverage;

  always_comb begin
    in_prefix_next    = in_prefix && low;
    prefix_end_next   = (in_prefix && low) ? we : prefix_end;
    suffix_start_next = (low && !suffix_active) ? ws : suffix_start;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_coverage <= '0;
    end else if (cfg_valid) begin
      min_coverage <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_prefix     <= 1'b1;
      prefix_end    <= '0;
      suffix_active <= 1'b0;
      suffix_start  <= '0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        in_prefix     <= 1'b1;
        prefix_end    <= '0;
        suffix_active <= 1'b0;
        suffix_start  <= '0;
      end else begin
        in_prefix     <= in_prefix_next;
        prefix_end    <= prefix_end_next;
        suffix_active <= low;
        suffix_start  <= suffix_start_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (accept && s_axis_tlast) begin
      job_valid <= 1'b1;
    end else if (job_take) begin
      job_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_axis_tlast) begin
      job_l <= prefix_end_next;
      job_r <= low ? suffix_start_next : sz;
      job_s <= sz;
    end
  end

endmodule

FILE: src/cets_plan.sv
// ----------------------------------------------------------------------------
// cets_plan
// picks the trim case, builds the segment list, drops repeated starts, sorts
// ----------------------------------------------------------------------------
module cets_plan #(
  parameter int unsigned POS_BITS = cets_pkg::POS_BITS_DEF
) (
  input  logic [POS_BITS-1:0]                          l,
  input  logic [POS_BITS-1:0]                          r,
  input  logic [POS_BITS-1:0]                          s,
  output logic [cets_pkg::NSEG-1:0][POS_BITS-1:0]      seg_st,
  output logic [cets_pkg::NSEG-1:0][POS_BITS-1:0]      seg_en,
  output logic [cets_pkg::SEG_CNT_W-1:0]               seg_cnt
);
  import cets_pkg::*;

  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

  trim_case_t                       tcase;
  logic [POS_BITS-1:0]              lp1, rm1;
  logic [NSEG-1:0][POS_BITS-1:0]    st, en;
  logic [NSEG-1:0]                  v, keep;
  logic [NSEG-1:0][SEG_CNT_W-1:0]   rank;

  assign lp1 = l + POS_ONE;
  assign rm1 = r - POS_ONE;

  always_comb begin
    if (l > POS_ONE && r < s && r > POS_ONE) begin
      tcase = CASE_BOTH;
    end else if (l > POS_ONE && l < s && r == s) begin
      tcase = CASE_LEFT;
    end else if (l == '0 && r < s && r > POS_ONE) begin
      tcase = CASE_RIGHT;
    end else begin
      tcase = CASE_WHOLE;
    end
  end

  always_comb begin
    st = '0;
    en = '0;
    v  = '0;
    unique case (tcase)
      CASE_BOTH: begin
        st[0] = POS_ONE; en[0] = l;
        st[1] = lp1;     en[1] = rm1;
        st[2] = r;       en[2] = s;
        v     = 3'b111;
      end
      CASE_LEFT: begin
        st[0] = POS_ONE; en[0] = l;
        st[1] = lp1;     en[1] = s;
        v     = 3'b011;
      end
      CASE_RIGHT: begin
        st[0] = r;       en[0] = s;
        st[1] = POS_ONE; en[1] = rm1;
        v     = 3'b011;
      end
      default: begin
        st[0] = POS_ONE; en[0] = s;
        v     = 3'b001;
      end
    endcase
  end

  // a later segment with an already used start is dropped
  always_comb begin
    keep[0] = v[0];
    keep[1] = v[1] && (st[1] != st[0]);
    keep[2] = v[2] && (st[2] != st[0]) && !(keep[1] && (st[2] == st[1]));
  end

  always_comb begin
    for (int i = 0; i < NSEG; i++) begin
      rank[i] = '0;
      for (int j = 0; j < NSEG; j++) begin
        if (j != i && keep[j] && (st[j] < st[i])) begin
          rank[i] = rank[i] + SEG_CNT_W'(1);
        end
      end
    end
  end

  always_comb begin
    seg_st = '0;
    seg_en = '0;
    for (int k = 0; k < NSEG; k++) begin
      for (int i = 0; i < NSEG; i++) begin
        if (keep[i] && rank[i] == SEG_CNT_W'(k)) begin
          seg_st[k] = st[i];
          seg_en[k] = en[i];
        end
      end
    end
  end

  assign seg_cnt = SEG_CNT_W'(keep[0]) + SEG_CNT_W'(keep[1]) + SEG_CNT_W'(keep[2]);

endmodule

FILE: src/cets_emit.sv
// ----------------------------------------------------------------------------
// cets_emit
// segment buffer of one sequence, sends its segments one word at a time
// ----------------------------------------------------------------------------
`include "coverage_end_trim_segmenter_defines.svh"

module cets_emit #(
  parameter int unsigned POS_BITS = cets_pkg::POS_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     job_valid,
  output logic                                     job_take,
  input  logic [cets_pkg::NSEG-1:0][POS_BITS-1:0]  plan_st,
  input  logic [cets_pkg::NSEG-1:0][POS_BITS-1:0]  plan_en,
  input  logic [cets_pkg::SEG_CNT_W-1:0]           plan_cnt,
  output logic                                     m_axis_tvalid,
  input  logic                                     m_axis_tready,
  output logic [cets_pkg::M_TDATA_W-1:0]           m_axis_tdata,
  output logic                                     m_axis_tlast
);
  import cets_pkg::*;

  logic                          busy;
  logic [SEG_CNT_W-1:0]          cnt;
  logic [SEG_CNT_W-1:0]          idx;
  logic [NSEG-1:0][POS_BITS-1:0] st, en;
  logic                          at_last;
  logic [POS_BITS+OUT_POS_W-1:0] st_wide, en_wide;

  assign at_last  = (idx == cnt - SEG_CNT_W'(1));
  assign job_take = !busy || (m_axis_tready && at_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      idx  <= '0;
    end else if (job_valid && job_take) begin
      busy <= 1'b1;
      cnt  <= plan_cnt;
      idx  <= '0;
    end else if (busy && m_axis_tready) begin
      if (at_last) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + SEG_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_valid && job_take) begin
      st <= plan_st;
      en <= plan_en;
    end
  end

  assign st_wide = {{OUT_POS_W{1'b0}}, st[idx]};
  assign en_wide = {{OUT_POS_W{1'b0}}, en[idx]};

  assign m_axis_tvalid = busy;
  assign m_axis_tdata  = {en_wide[OUT_POS_W-1:0], st_wide[OUT_POS_W-1:0]};
  assign m_axis_tlast  = at_last;

  `CETS_ASSERT(a_idx_in_range, !busy || (cnt != '0 && idx < cnt), "segment index out of range")
  `CETS_ASSERT(a_sorted, !busy || cnt < SEG_CNT_W'(2) || st[0] < st[1], "segments out of order")
  `CETS_ASSERT_NEXT(a_load, job_valid && job_take, busy && idx == '0, "job not loaded")
  `CETS_ASSERT_NEXT(a_hold, busy && !m_axis_tready, busy && $stable(idx), "stalled segment moved")

endmodule

FILE: src/coverage_end_trim_segmenter.sv
// ----------------------------------------------------------------------------
// coverage_end_trim_segmenter
// end trimming of a sequence by low-coverage runs at both ends
// ----------------------------------------------------------------------------
// usage
//   cfg_valid/cfg_data writes min_coverage; cfg_ready is always high
//   s_axis takes one coverage window per word, tlast on the final window
//   of a sequence; non-final windows produce nothing on m_axis
//   m_axis gives 1 to 3 segments per sequence in ascending start order,
//   tlast on the last segment of the sequence
// timing
//   one window per cycle while s_axis_tready is high; the final window
//   passes through the job register into the segment buffer, which offers
//   the segments one per cycle while m_axis_tready is high
//   a final window waits in a one-deep job register while the segment
//   buffer drains; s_axis_tready drops only while that register is full
//   and the buffer cannot take it
// reset
//   rst is synchronous, clears the threshold and the run tracking, and
//   empties the job register and segment buffer; no clearing pass
//   a stalled m_axis holds its segment and index unchanged
// ----------------------------------------------------------------------------
module coverage_end_trim_segmenter #(
  parameter int unsigned POS_BITS = cets_pkg::POS_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [cets_pkg::THR_W-1:0]     cfg_data,       // min_coverage
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [cets_pkg::S_TDATA_W-1:0] s_axis_tdata,   // win_start, win_end, coverage, seq_size
  input  logic                           s_axis_tlast,   // last_window
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [cets_pkg::M_TDATA_W-1:0] m_axis_tdata,   // seg_start, seg_end
  output logic                           m_axis_tlast    // seg_last
);
  import cets_pkg::*;

  logic                          job_valid, job_take;
  logic [POS_BITS-1:0]           job_l, job_r, job_s;
  logic [NSEG-1:0][POS_BITS-1:0] plan_st, plan_en;
  logic [SEG_CNT_W-1:0]          plan_cnt;

  assign cfg_ready = 1'b1;

  cets_track #(.POS_BITS(POS_BITS)) u_track (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .job_valid     (job_valid),
    .job_take      (job_take),
    .job_l         (job_l),
    .job_r         (job_r),
    .job_s         (job_s)
  );

  cets_plan #(.POS_BITS(POS_BITS)) u_plan (
    .l       (job_l),
    .r       (job_r),
    .s       (job_s),
    .seg_st  (plan_st),
    .seg_en  (plan_en),
    .seg_cnt (plan_cnt)
  );

  cets_emit #(.POS_BITS(POS_BITS)) u_emit (
    .clk           (clk),
    .rst           (rst),
    .job_valid     (job_valid),
    .job_take      (job_take),
    .plan_st       (plan_st),
    .plan_en       (plan_en),
    .plan_cnt      (plan_cnt),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: test/tb_coverage_end_trim_segmenter.sv
// ----------------------------------------------------------------------------
// tb_coverage_end_trim_segmenter
// self-checking bench for the coverage end trim segmenter: coverage windows
// stream in with bursts and gaps, segments stream out against a stalling
// receiver and are compared field by field with a local model of the trim
// ----------------------------------------------------------------------------
module tb_coverage_end_trim_segmenter;
  timeunit 1ns;
  timeprecision 1ps;
  import cets_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int SETTLE      = 8;
  localparam int LONG_HOLD   = 300;

  typedef struct {
    logic [IN_POS_W-1:0] win_start;
    logic [IN_POS_W-1:0] win_end;
    logic [COV_W-1:0]    coverage;
    logic [IN_POS_W-1:0] seq_size;
    logic                last_window;
  } window_t;

  typedef struct {
    logic [OUT_POS_W-1:0] seg_start;
    logic [OUT_POS_W-1:0] seg_end;
    logic                 seg_last;
  } segment_t;

  typedef enum {RX_OPEN, RX_RANDOM, RX_PERIODIC} rx_mode_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [THR_W-1:0]     cfg_data = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata = '0;  // win_start, win_end, coverage, seq_size
  logic                 s_axis_tlast = 1'b0; // last_window
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;       // seg_start, seg_end
  logic                 m_axis_tlast;       // seg_last

  coverage_end_trim_segmenter DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // trim model state
  logic [THR_W-1:0]    thr_q      = '0;
  logic                lead_open  = 1'b1;
  logic [IN_POS_W-1:0] lead_end   = '0;
  logic                tail_open  = 1'b0;
  logic [IN_POS_W-1:0] tail_start = '0;

  segment_t seg_expected[$];
  window_t  pending_q[$];

  int mismatches   = 0;
  int windows_seen = 0;
  int segs_seen    = 0;
  int cfg_writes   = 0;
  int case_hits[4] = '{0, 0, 0, 0};

  function automatic void trim_window(window_t w);
    logic                low;
    logic                dup;
    logic [IN_POS_W-1:0] l, r, sz, ts, te;
    logic [IN_POS_W-1:0] cs[3];
    logic [IN_POS_W-1:0] ce[3];
    logic [IN_POS_W-1:0] st[3];
    logic [IN_POS_W-1:0] en[3];
    int                  nc, n, i, j;
    trim_case_t          kind;
    segment_t            seg;
    low = w.coverage < {thr_q, 8'h00};
    if (lead_open && low) lead_end = w.win_end;
    else lead_open = 1'b0;
    if (low) begin
      if (!tail_open) begin
        tail_start = w.win_start;
        tail_open  = 1'b1;
      end
    end else begin
      tail_open = 1'b0;
    end
    if (!w.last_window) return;

    l  = lead_end;
    sz = w.seq_size;
    r  = tail_open ? tail_start : sz;
    if (l > 1 && r < sz && r > 1) kind = CASE_BOTH;
    else if (l > 1 && l < sz && r == sz) kind = CASE_LEFT;
    else if (l == 0 && r < sz && r > 1) kind = CASE_RIGHT;
    else kind = CASE_WHOLE;

    // candidate segments in the order they are formed
    case (kind)
      CASE_BOTH: begin
        cs[0] = 1;     ce[0] = l;
        cs[1] = l + 1; ce[1] = r - 1;
        cs[2] = r;     ce[2] = sz;
        nc = 3;
      end
      CASE_LEFT: begin
        cs[0] = 1;     ce[0] = l;
        cs[1] = l + 1; ce[1] = sz;
        nc = 2;
      end
      CASE_RIGHT: begin
        cs[0] = r;     ce[0] = sz;
        cs[1] = 1;     ce[1] = r - 1;
        nc = 2;
      end
      default: begin
        cs[0] = 1;     ce[0] = sz;
        nc = 1;
      end
    endcase

    // a repeated start keeps only the first one formed
    n = 0;
    for (i = 0; i < nc; i++) begin
      dup = 1'b0;
      for (j = 0; j < n; j++) if (st[j] == cs[i]) dup = 1'b1;
      if (!dup) begin
        st[n] = cs[i];
        en[n] = ce[i];
        n++;
      end
    end

    // ascending start order
    for (i = 1; i < n; i++) begin
      ts = st[i];
      te = en[i];
      j  = i - 1;
      while (j >= 0 && st[j] > ts) begin
        st[j+1] = st[j];
        en[j+1] = en[j];
        j--;
      end
      st[j+1] = ts;
      en[j+1] = te;
    end

    for (i = 0; i < n; i++) begin
      seg.seg_start = st[i];
      seg.seg_end   = en[i];
      seg.seg_last  = (i == n - 1);
      seg_expected.insert(seg_expected.size(), seg);
    end
    case_hits[int'(kind)]++;

    lead_open  = 1'b1;
    lead_end   = '0;
    tail_open  = 1'b0;
    tail_start = '0;
  endfunction

  // sender: bursts of random length with random gaps
  window_t on_bus;
  int      burst_left = 0;
  int      gap_left   = 0;
  int      gap_max    = 3;

  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        trim_window(on_bus);
        windows_seen++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_axis_tvalid <= 1'b0;
        end else if (pending_q.size() > 0) begin
          on_bus = pending_q.pop_front();
          s_axis_tdata  <= {on_bus.seq_size, on_bus.coverage, on_bus.win_end, on_bus.win_start};
          s_axis_tlast  <= on_bus.last_window;
          s_axis_tvalid <= 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 16);
            gap_left   = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
          end
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: stall pattern plus an on-request long hold-off
  rx_mode_t rx_mode   = RX_OPEN;
  int       hold_req  = 0;
  int       hold_done = 0;
  int       hold_left = 0;
  int       rx_tick   = 0;

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_tick++;
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (hold_done != hold_req) begin
        hold_done = hold_req;
        hold_left = LONG_HOLD;
        m_axis_tready <= 1'b0;
      end else begin
        case (rx_mode)
          RX_OPEN:   m_axis_tready <= 1'b1;
          RX_RANDOM: m_axis_tready <= ($urandom_range(0, 99) < 60);
          default:   m_axis_tready <= ((rx_tick % 11) > 3);
        endcase
      end
    end
  end

  function automatic void check_field(string fname, logic [31:0] got, logic [31:0] want);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, fname, want, got);
    end
  endfunction

  segment_t seg_want;

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      segs_seen++;
      if (seg_expected.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected segment, expected none, got %h last %b",
                 $time, m_axis_tdata, m_axis_tlast);
      end else begin
        seg_want = seg_expected.pop_front();
        check_field("seg_start", m_axis_tdata[OUT_POS_W-1:0], seg_want.seg_start);
        check_field("seg_end", m_axis_tdata[2*OUT_POS_W-1:OUT_POS_W], seg_want.seg_end);
        check_field("seg_last", {31'd0, m_axis_tlast}, {31'd0, seg_want.seg_last});
      end
    end
  end

  // watchdog on cycles with no word moving anywhere
  int quiet = 0;

  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("%0t: timeout, %0d segments still expected", $time, seg_expected.size());
      $display("tb_coverage_end_trim_segmenter NOT OK");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic write_threshold(logic [THR_W-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    thr_q = v;
    cfg_writes++;
  endtask

  task automatic drain();
    do @(negedge clk); while (pending_q.size() != 0 || s_axis_tvalid || seg_expected.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic push_win(logic [31:0] ws, logic [31:0] we, logic [23:0] cov,
                          logic [31:0] sz, logic last);
    window_t w;
    w.win_start   = ws;
    w.win_end     = we;
    w.coverage    = cov;
    w.seq_size    = sz;
    w.last_window = last;
    pending_q.insert(pending_q.size(), w);
  endtask

  function automatic logic [COV_W-1:0] pick_cov(bit want_low);
    logic [31:0] lim;
    lim = {thr_q, 8'h00};
    if (want_low && lim != 0) begin
      case ($urandom_range(0, 3))
        0:       return COV_W'(lim - 1);
        1:       return '0;
        default: return COV_W'($urandom_range(0, lim - 1));
      endcase
    end
    case ($urandom_range(0, 3))
      0:       return COV_W'(lim);
      1:       return 24'hFFFFFF;
      default: return COV_W'($urandom_range(lim, 24'hFFFFFF));
    endcase
  endfunction

  // well-formed sequence: leading low run, middle, trailing low run
  task automatic add_sequence(int nwin, output int pushed);
    logic [31:0] step, ws, we, sz;
    int          nlead, ntail;
    bit          low;
    step = $urandom_range(1, 4000);
    if ($urandom_range(0, 9) == 0) step = $urandom_range(1, 32'h0FFFFFFF);
    nlead = $urandom_range(0, nwin);
    ntail = $urandom_range(0, nwin - nlead);
    case ($urandom_range(0, 3))
      0:       sz = nwin * step;
      1:       sz = nwin * step + $urandom_range(1, 3);
      2:       sz = nwin * step - $urandom_range(0, 2);
      default: sz = $urandom;
    endcase
    ws = 1;
    for (int i = 0; i < nwin; i++) begin
      we  = ws + step - 1;
      low = (i < nlead) || (i >= nwin - ntail);
      if ($urandom_range(0, 19) == 0) low = !low;
      push_win(ws, we, pick_cov(low), ($urandom_range(0, 1) || i == nwin - 1) ? sz : $urandom,
               i == nwin - 1);
      ws = we + 1;
    end
    pushed = nwin;
  endtask

  // noise: every field random, with tlast always on the final window
  task automatic add_noise(int nwin, output int pushed);
    for (int i = 0; i < nwin; i++)
      push_win($urandom, $urandom, COV_W'($urandom), $urandom,
               (i == nwin - 1) || ($urandom_range(0, 7) == 0));
    pushed = nwin;
  endtask

  task automatic run_phase(logic [THR_W-1:0] thr, int gaps, rx_mode_t rxm, int count);
    int done, got;
    write_threshold(thr);
    gap_max = gaps;
    rx_mode = rxm;
    done = 0;
    while (done < count) begin
      if ($urandom_range(0, 9) < 7) add_sequence($urandom_range(1, 8), got);
      else add_noise($urandom_range(1, 4), got);
      done += got;
    end
    drain();
  endtask

  localparam logic [23:0] LO = 24'd100;
  localparam logic [23:0] HI = 24'd5000;

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed, threshold 10 so low means below 2560
    write_threshold(16'd10);
    gap_max = 2;
    rx_mode = RX_RANDOM;
    push_win(1, 100, HI, 100, 1);                      // whole sequence
    push_win(1, 100, LO, 0, 0);                        // both ends
    push_win(101, 200, HI, 0, 0);
    push_win(201, 300, LO, 300, 1);
    push_win(1, 100, LO, 0, 0);                        // left end only
    push_win(101, 200, HI, 200, 1);
    push_win(1, 100, HI, 0, 0);                        // right end only
    push_win(101, 200, LO, 200, 1);
    push_win(1, 100, LO, 0, 0);                        // overlapping segments
    push_win(101, 200, HI, 0, 0);
    push_win(50, 60, LO, 200, 1);
    push_win(1, 10, LO, 0, 0);                         // repeated start
    push_win(5, 8, HI, 0, 0);
    push_win(11, 20, LO, 30, 1);
    push_win(1, 32'hFFFFFFFF, LO, 0, 0);               // prefix end wraps on +1
    push_win(2, 3, HI, 0, 0);
    push_win(5, 9, LO, 32'hFFFFFFFF, 1);
    push_win(7, 20, LO, 50, 1);                        // lone low window
    push_win(32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 0, 1);
    push_win(1, 1, 24'h000000, 10, 1);                 // prefix end of one
    push_win(1, 50, 24'd2559, 0, 0);                   // just below threshold
    push_win(51, 100, 24'd2560, 100, 1);               // exactly at threshold
    drain();

    run_phase(16'd0, 3, RX_RANDOM, 40);
    run_phase(16'hFFFF, 0, RX_PERIODIC, 30);
    run_phase(16'($urandom_range(1, 200)), 6, RX_RANDOM, 45);

    // long receiver hold-off while short sequences keep coming
    write_threshold(16'd3);
    gap_max = 0;
    rx_mode = RX_OPEN;
    hold_req++;
    for (int k = 0; k < 40; k++) begin
      if (k % 2 == 0) push_win(k + 1, k + 10, pick_cov(1), k + 20, 1);
      else push_win(1, k + 1, pick_cov(0), k + 5, 1);
    end
    drain();

    run_phase(16'($urandom), 30, RX_PERIODIC, 40);
    run_phase(16'd1, 4, RX_RANDOM, 40);
    run_phase(16'd10, 0, RX_OPEN, 40);

    $display("covered %0d windows, %0d segments over %0d threshold settings",
             windows_seen, segs_seen, cfg_writes);
    $display("trim cases: both %0d, left %0d, right %0d, whole %0d",
             case_hits[int'(CASE_BOTH)], case_hits[int'(CASE_LEFT)],
             case_hits[int'(CASE_RIGHT)], case_hits[int'(CASE_WHOLE)]);
    if (mismatches == 0 && seg_expected.size() == 0) begin
      $display("tb_coverage_end_trim_segmenter OK");
    end else begin
      $display("tb_coverage_end_trim_segmenter NOT OK");
    end
    $finish;
  end

endmodule
